@@ rtl/bslpd_pkg.sv @@
// ----------------------------------------------------------------------------
// bslpd_pkg
// shared types and constants of the button short/long press detector
// ----------------------------------------------------------------------------
package bslpd_pkg;

  localparam int NUM_BUTTONS_DEF = 5;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int NUM_LEVELS      = 5;

  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int EVENT_W    = 4;
  localparam int CUR_W      = 3;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CFG_W-1:0] SHORT_TICKS_RST   = 16'd10;
  localparam logic [CFG_W-1:0] LONG_TICKS_RST    = 16'd200;
  localparam logic [CFG_W-1:0] RELEASE_TICKS_RST = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT   = 2'd0,
    CFG_LONG    = 2'd1,
    CFG_RELEASE = 2'd2
  } cfg_idx_e;

  // threshold compares of one lane, on its updated counters
  typedef struct packed {
    logic gt_long;
    logic gt_short;
    logic gt_rel;
  } lane_stat_t;

  // control from the merge stage to one lane
  typedef struct packed {
    logic below;  // a lower button is pressed this tick
    logic hit;    // lane is the active button before this tick
    logic clamp;  // clamp held count to the long threshold
    logic clr;    // clear released count, gesture ends
  } lane_ctl_t;

  // packed with event_code in the lowest bits
  typedef struct packed {
    logic             long_held;
    logic [CUR_W-1:0] current_button;
    logic             action_strobe;
    logic [EVENT_W-1:0] event_code;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

@@ rtl/button_short_long_press_detector.sv @@
// a result is held in the output register, or first in the skid entry while
// m_axis stalls; throughput: one tick per cycle while the skid entry is empty;
// lane counters, active button and flags update from each accepted transfer
// a two-deep output buffer keeps input open while one result is pending
// reset: asynchronous, active low; clears counters, active button, flags,
// and loads the thresholds with 10, 200 and 10 ticks
// ----------------------------------------------------------------------------
// button_short_long_press_detector
// per-button hold/release lanes, merge stage judging short and long presses
// ----------------------------------------------------------------------------
module button_short_long_press_detector #(
  parameter int NUM_BUTTONS = bslpd_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_WIDTH = bslpd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bslpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bslpd_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // hour_level, up_level, down_level, select_level, clear_level, zero pad
  input  logic [bslpd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // event_code[3:0], action_strobe, current_button[2:0], long_held, zero pad
  output logic [bslpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import bslpd_pkg::*;

  logic [CFG_W-1:0] short_q, long_q, rel_q;
  logic [NUM_BUTTONS-1:0] level;
  lane_stat_t stat [NUM_BUTTONS];
  lane_ctl_t  ctl  [NUM_BUTTONS];
  result_t    res, res_out;
  logic       in_ready, acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= SHORT_TICKS_RST;
      long_q  <= LONG_TICKS_RST;
      rel_q   <= RELEASE_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHORT:   short_q <= cfg_data_i;
        CFG_LONG:    long_q  <= cfg_data_i;
        CFG_RELEASE: rel_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = in_ready;
  assign acc           = s_axis_tvalid && in_ready;

  // buttons past the five inputs read as released
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    if (i < NUM_LEVELS) begin : g_in
      assign level[i] = s_axis_tdata[i];
    end else begin : g_none
      assign level[i] = 1'b0;
    end

    bslpd_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_lane (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .upd_i          (acc),
      .level_i        (level[i]),
      .ctl_i          (ctl[i]),
      .short_ticks_i  (short_q),
      .long_ticks_i   (long_q),
      .release_ticks_i(rel_q),
      .stat_o         (stat[i])
    );
  end

  bslpd_merge #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (acc),
    .level_i(level),
    .stat_i (stat),
    .ctl_o  (ctl),
    .res_o  (res)
  );

  bslpd_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (in_ready),
    .in_data_i  (res),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (res_out)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - RESULT_W){1'b0}}, res_out};

endmodule

@@ rtl/bslpd_lane.sv @@
// ----------------------------------------------------------------------------
// bslpd_lane
// hold and release counters of one button with threshold compares
// ----------------------------------------------------------------------------
module bslpd_lane #(
  parameter int COUNT_WIDTH = bslpd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        upd_i,
  input  logic                        level_i,
  input  bslpd_pkg::lane_ctl_t        ctl_i,
  input  logic [bslpd_pkg::CFG_W-1:0] short_ticks_i,
  input  logic [bslpd_pkg::CFG_W-1:0] long_ticks_i,
  input  logic [bslpd_pkg::CFG_W-1:0] release_ticks_i,
  output bslpd_pkg::lane_stat_t       stat_o
);
  import bslpd_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] held_q, held_d, held_n;
  logic [COUNT_WIDTH-1:0] rel_q, rel_d, rel_n;

  always_comb begin
    held_n = held_q;
    rel_n  = rel_q;
    if (level_i) begin
      rel_n  = '0;
      held_n = (held_q == CNT_MAX) ? held_q : held_q + 1'b1;
    end else if (!ctl_i.below && ctl_i.hit) begin
      held_n = '0;
      rel_n  = (rel_q == CNT_MAX) ? rel_q : rel_q + 1'b1;
    end
  end

  assign stat_o.gt_long  = CMP_W'(held_n) > CMP_W'(long_ticks_i);
  assign stat_o.gt_short = CMP_W'(held_n) > CMP_W'(short_ticks_i);
  assign stat_o.gt_rel   = CMP_W'(rel_n)  > CMP_W'(release_ticks_i);

  assign held_d = ctl_i.clamp ? COUNT_WIDTH'(long_ticks_i) : held_n;
  assign rel_d  = ctl_i.clr ? '0 : rel_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      rel_q  <= '0;
    end else if (upd_i) begin
      held_q <= held_d;
      rel_q  <= rel_d;
    end
  end

endmodule

@@ rtl/bslpd_merge.sv @@
// ----------------------------------------------------------------------------
// bslpd_merge
// picks the active button from the lanes and judges the gesture
// ----------------------------------------------------------------------------
module bslpd_merge #(
  parameter int NUM_BUTTONS = bslpd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    upd_i,
  input  logic [NUM_BUTTONS-1:0]  level_i,
  input  bslpd_pkg::lane_stat_t   stat_i [NUM_BUTTONS],
  output bslpd_pkg::lane_ctl_t    ctl_o  [NUM_BUTTONS],
  output bslpd_pkg::result_t      res_o
);
  import bslpd_pkg::*;

  localparam int AW = $clog2(NUM_BUTTONS + 1);

  logic [AW-1:0] act_q, act_d, act_scan;
  logic          short_q, short_d;
  logic          long_q, long_d;
  logic          any_below;
  logic          strobe;
  logic [EVENT_W-1:0] evt;
  lane_stat_t    sel;
  logic [AW:0]   dbl;
  logic [NUM_BUTTONS-1:0] below_v, hit_v, clamp_v, clr_v;

  always_comb begin
    any_below = 1'b0;
    act_scan  = act_q;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      below_v[i] = any_below;
      hit_v[i]   = (act_q == AW'(i + 1));
      any_below  = any_below | level_i[i];
      // last pressed in scan order wins
      if (level_i[i]) begin
        act_scan = AW'(i + 1);
      end
    end
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (act_scan == AW'(i + 1)) begin
        sel = stat_i[i];
      end
    end
  end

  always_comb begin
    dbl     = {act_scan, 1'b0};
    evt     = '0;
    strobe  = 1'b0;
    act_d   = act_scan;
    short_d = short_q;
    long_d  = long_q;
    if (act_scan != '0) begin
      if (sel.gt_long) begin
        if (!long_q) begin
          evt = EVENT_W'(dbl);
        end
        long_d = 1'b1;
        strobe = 1'b1;
      end else if (sel.gt_short) begin
        if (!short_q) begin
          evt = EVENT_W'(dbl - 1'b1);
        end
        short_d = 1'b1;
        strobe  = 1'b1;
      end
      if (sel.gt_rel) begin
        act_d   = '0;
        short_d = 1'b0;
        long_d  = 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      clamp_v[i] = (act_scan == AW'(i + 1)) && sel.gt_long;
      clr_v[i]   = (act_scan == AW'(i + 1)) && sel.gt_rel;
    end
  end

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_ctl
    assign ctl_o[g] = '{below: below_v[g], hit: hit_v[g], clamp: clamp_v[g], clr: clr_v[g]};
  end

  assign res_o.event_code     = evt;
  assign res_o.action_strobe  = strobe;
  assign res_o.current_button = CUR_W'(act_d);
  assign res_o.long_held      = long_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= '0;
      short_q <= 1'b0;
      long_q  <= 1'b0;
    end else if (upd_i) begin
      act_q   <= act_d;
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

  a_strobe_needs_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> act_d != '0)
    else $error("strobe without an active button");

  a_event_needs_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt != '0 |-> strobe)
    else $error("press event without strobe");

  a_flags_need_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (long_q || short_q) |-> act_q != '0)
    else $error("gesture flag set with no active button");

  a_clamp_only_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && sel.gt_long && act_scan != '0 |=> !sel.gt_long || $past(act_scan) != act_scan
      || $past(long_q) == 1'b0 || long_q)
    else $error("long flag lost while long press holds");

endmodule

@@ rtl/bslpd_obuf.sv @@
// ----------------------------------------------------------------------------
// bslpd_obuf
// output register with a skid entry, two results deep
// ----------------------------------------------------------------------------
module bslpd_obuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bslpd_pkg::result_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bslpd_pkg::result_t  out_data_o
);
  import bslpd_pkg::*;

  logic    out_v_q, skid_v_q;
  result_t out_q, skid_q;
  logic    acc, load_out;

  assign in_ready_o  = !skid_v_q;
  assign acc         = in_valid_i && in_ready_o;
  assign load_out    = !out_v_q || out_ready_i;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q  <= skid_v_q || acc;
      skid_v_q <= 1'b0;
    end else if (acc) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_v_q ? skid_q : in_data_i;
    end else if (acc) begin
      skid_q <= in_data_i;
    end
  end

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry holds a result ahead of the output register");

  a_skid_drains_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && out_ready_i |=> out_v_q && out_q == $past(skid_q))
    else $error("skid entry not moved to the output register");

  a_no_loss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_ready_i && !skid_v_q && in_valid_i |=> skid_v_q)
    else $error("transfer accepted with no room kept");

endmodule

@@ tb/button_short_long_press_detector_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_short_long_press_detector_tb
// Drives button level ticks through the stream input and checks every result
// against a tick-accurate predictor of the hold and release counters.
// Random gaps and stalls are used on both sides. Several threshold settings
// are covered, among them zero, all-ones and long below short.
// ----------------------------------------------------------------------------
module button_short_long_press_detector_tb;
  import bslpd_pkg::*;

  localparam int CYCLE_LIMIT   = 100_000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_W-1:0]       cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // hour_level, up_level, down_level, select_level, clear_level, zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // event_code[3:0], action_strobe, current_button[2:0], long_held, zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int cycle_count = 0;

  button_short_long_press_detector i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  class press_scoreboard;
    logic [CFG_W-1:0]           short_ticks;
    logic [CFG_W-1:0]           long_ticks;
    logic [CFG_W-1:0]           rel_ticks;
    logic [COUNT_WIDTH_DEF-1:0] held_ticks [NUM_BUTTONS_DEF];
    logic [COUNT_WIDTH_DEF-1:0] released_ticks [NUM_BUTTONS_DEF];
    logic [CUR_W-1:0]           active_btn;
    bit                         short_seen;
    bit                         long_seen;
    result_t                    expected_q [$];
    int                         errors;

    function new();
      short_ticks = SHORT_TICKS_RST;
      long_ticks  = LONG_TICKS_RST;
      rel_ticks   = RELEASE_TICKS_RST;
      for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
        held_ticks[i]     = '0;
        released_ticks[i] = '0;
      end
      active_btn = '0;
      short_seen = 1'b0;
      long_seen  = 1'b0;
      errors     = 0;
    endfunction

    function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_SHORT:   short_ticks = val;
        CFG_LONG:    long_ticks  = val;
        CFG_RELEASE: rel_ticks   = val;
        default: ;
      endcase
    endfunction

    function logic [COUNT_WIDTH_DEF-1:0] sat_inc(logic [COUNT_WIDTH_DEF-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    // one scan tick: update the lanes in scan order, then judge the active one
    function void note_tick(logic [NUM_LEVELS-1:0] lv);
      result_t     r;
      int unsigned btn;
      int          k;
      r = '0;
      for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
        if (i < NUM_LEVELS && lv[i]) begin
          released_ticks[i] = '0;
          held_ticks[i]     = sat_inc(held_ticks[i]);
          active_btn        = CUR_W'(i + 1);
        end else if (active_btn == CUR_W'(i + 1)) begin
          held_ticks[i]     = '0;
          released_ticks[i] = sat_inc(released_ticks[i]);
        end
      end
      if (active_btn != '0) begin
        btn = active_btn;
        k   = btn - 1;
        if (held_ticks[k] > long_ticks) begin
          if (!long_seen) r.event_code = EVENT_W'(2 * btn);
          long_seen     = 1'b1;
          held_ticks[k] = COUNT_WIDTH_DEF'(long_ticks);
          r.action_strobe = 1'b1;
        end else if (held_ticks[k] > short_ticks) begin
          if (!short_seen) r.event_code = EVENT_W'(2 * btn - 1);
          short_seen = 1'b1;
          r.action_strobe = 1'b1;
        end
        if (released_ticks[k] > rel_ticks) begin
          released_ticks[k] = '0;
          active_btn = '0;
          short_seen = 1'b0;
          long_seen  = 1'b0;
        end
      end
      r.current_button = active_btn;
      r.long_held      = long_seen;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      result_t got;
      result_t exp;
      got = result_t'(tdata[RESULT_W-1:0]);
      if (expected_q.size() == 0) begin
        $error("result transfer with no tick pending: tdata %h", tdata);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.event_code != exp.event_code) begin
        $error("event_code mismatch: expected %0d, actual %0d", exp.event_code,
               got.event_code);
        errors++;
      end
      if (got.action_strobe != exp.action_strobe) begin
        $error("action_strobe mismatch: expected %0d, actual %0d", exp.action_strobe,
               got.action_strobe);
        errors++;
      end
      if (got.current_button != exp.current_button) begin
        $error("current_button mismatch: expected %0d, actual %0d", exp.current_button,
               got.current_button);
        errors++;
      end
      if (got.long_held != exp.long_held) begin
        $error("long_held mismatch: expected %0d, actual %0d", exp.long_held,
               got.long_held);
        errors++;
      end
      if (tdata[OUT_TDATA_W-1:RESULT_W] != '0) begin
        $error("tdata pad mismatch: expected 0, actual %0h", tdata[OUT_TDATA_W-1:RESULT_W]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  press_scoreboard sb = new();

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL button_short_long_press_detector");
      $finish;
    end
  end

  // result side: random stall after each transfer, none in burst stretches
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        stall_left = rx_burst ? 0 : $urandom_range(0, 11);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input logic [NUM_LEVELS-1:0] lv);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-NUM_LEVELS){1'b0}}, lv};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_tick(lv);
  endtask

  task automatic drain_ticks();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.apply_cfg(idx, val);
  endtask

  // thresholds change only with no tick in flight; the unused index goes last
  task automatic configure(input logic [CFG_W-1:0] short_v, input logic [CFG_W-1:0] long_v,
                           input logic [CFG_W-1:0] rel_v);
    drain_ticks();
    write_cfg(CFG_SHORT, short_v);
    write_cfg(CFG_LONG, long_v);
    write_cfg(CFG_RELEASE, rel_v);
    write_cfg(CFG_UNUSED_IDX, CFG_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // mostly press-hold-release gestures, some multi-press and noise ticks
  task automatic run_gestures(input int n_items, input int hold_cap, input int rel_cap);
    int sent;
    int len;
    int btn;
    logic [NUM_LEVELS-1:0] lv;
    sent = 0;
    while (sent < n_items) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 14) == 0) drain_ticks();
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(1, 4);
        repeat (len) send_tick(NUM_LEVELS'($urandom));
        sent += len;
      end else begin
        btn = $urandom_range(0, NUM_LEVELS - 1);
        len = $urandom_range(0, hold_cap);
        repeat (len) begin
          lv = '0;
          lv[btn] = 1'b1;
          if ($urandom_range(0, 7) == 0) lv |= NUM_LEVELS'($urandom);
          send_tick(lv);
        end
        sent += len;
        len = $urandom_range(0, rel_cap);
        repeat (len) begin
          lv = '0;
          if ($urandom_range(0, 9) == 0) lv[$urandom_range(0, NUM_LEVELS - 1)] = 1'b1;
          send_tick(lv);
        end
        sent += len;
      end
    end
  endtask

  initial begin : stimulus
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_SHORT;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset thresholds: idle, all pressed, each button alone, then a short press
    send_tick(5'b00000);
    send_tick(5'b11111);
    send_tick(5'b00001);
    send_tick(5'b00010);
    send_tick(5'b00100);
    send_tick(5'b01000);
    send_tick(5'b10000);
    send_tick(5'b00000);
    send_tick(5'b00000);
    repeat (12) send_tick(5'b00010);
    run_gestures(40, 14, 13);

    configure(16'd3, 16'd8, 16'd2);
    run_gestures(90, 12, 4);

    configure(16'd0, 16'd0, 16'd0);
    run_gestures(60, 3, 2);

    // long threshold below short: long test takes over
    configure(16'd6, 16'd2, 16'd4);
    run_gestures(60, 9, 6);

    configure(16'd10, 16'd30, 16'd10);
    run_gestures(100, 36, 13);

    configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_gestures(30, 5, 5);

    configure(16'd1, 16'd4, 16'd1);
    run_gestures(40, 7, 3);

    drain_ticks();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS button_short_long_press_detector");
    end else begin
      $display("FAIL button_short_long_press_detector");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bslpd_pkg.sv
rtl/bslpd_lane.sv
rtl/bslpd_merge.sv
rtl/bslpd_obuf.sv
rtl/button_short_long_press_detector.sv
tb/button_short_long_press_detector_tb.sv
